### src/tsb_pkg.sv
// Shared constants, codes and the job type of the slot packet bridge.
// Depends on nothing; every other file but tsb_ram refers to it by scoped names.
package tsb_pkg;

	localparam int RING_DEPTH   = 64;
	localparam int PACKET_BYTES = 64;
	localparam int STORE_SIZE   = RING_DEPTH * PACKET_BYTES;

	localparam int SLOT_W = $clog2(RING_DEPTH);
	localparam int OFF_W  = $clog2(PACKET_BYTES);
	localparam int ADDR_W = $clog2(STORE_SIZE);
	localparam int CFG_W  = 16;
	localparam int JQ_DEPTH = 2;
	localparam int JQ_PW    = $clog2(JQ_DEPTH);

	localparam logic [7:0] PKT_LEN     = 8'(PACKET_BYTES);
	localparam logic [7:0] HALF_POINT  = 8'd128;
	localparam logic [15:0] IDLE_MAX   = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RST = 16'd100;
	localparam logic [OFF_W-1:0] OFF_FIRST = OFF_W'(2);
	localparam logic [OFF_W-1:0] OFF_LAST  = OFF_W'(PACKET_BYTES - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

	localparam logic [2:0] CMD_HOST  = 3'd0;
	localparam logic [2:0] CMD_SLOT  = 3'd1;
	localparam logic [2:0] CMD_MS    = 3'd2;
	localparam logic [2:0] CMD_RXHDR = 3'd3;
	localparam logic [2:0] CMD_XMIT  = 3'd4;

	localparam logic [1:0] REG_NODE_ODD  = 2'd0;
	localparam logic [1:0] REG_DEAD_TIME = 2'd1;
	localparam logic [1:0] REG_XFER_DLY  = 2'd2;
	localparam logic [1:0] REG_FLUSH_TO  = 2'd3;

	// One unit of work for the transmit side: a packet to stream or an overflow beat.
	typedef struct packed {
		logic              ovf;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        len;
		logic [7:0]        stamp;
	} job_t;

	// Base address of a ring slot in the packet store.
	function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] slot);
		slot_base = ADDR_W'(slot) * ADDR_W'(PACKET_BYTES);
	endfunction

endpackage

### src/tsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/tsb_front.sv
// Front end: accepts beats, holds config, ring pointers and counters, writes the store
// and queues transmit jobs. Depends on tsb_pkg.
module tsb_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 cmd,
	input  logic [7:0]                 host_byte,
	input  logic [7:0]                 rx_length,
	input  logic [7:0]                 rx_stamp,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [tsb_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                       q_full,
	input  logic                       q_hit,
	input  logic                       b_hit,
	output logic [tsb_pkg::SLOT_W-1:0] fill_slot,
	output logic                       push,
	output tsb_pkg::job_t              job,
	output logic                       ram_we,
	output logic [tsb_pkg::ADDR_W-1:0] ram_waddr,
	output logic [7:0]                 ram_wdata
);

	logic        node_odd_q;
	logic [7:0]  dead_time_q;
	logic [7:0]  xfer_dly_q;
	logic [15:0] flush_to_q;

	logic [7:0]                 slot_count_q;
	logic [tsb_pkg::SLOT_W-1:0] write_slot_q;
	logic [tsb_pkg::SLOT_W-1:0] read_slot_q;
	logic [tsb_pkg::OFF_W-1:0]  fill_q;
	logic [15:0]                idle_q;

	logic                       accept;
	logic                       win_open;
	logic [8:0]                 c9, h9, sum9;
	logic [tsb_pkg::SLOT_W-1:0] nxt_write;
	logic                       have_full;
	logic                       may_flush;

	// host beats wait while their slot is read out; host/xmit beats wait on a full queue
	always_comb begin
		in_stall = 1'b0;
		if ((cmd == tsb_pkg::CMD_HOST) || (cmd == tsb_pkg::CMD_XMIT)) begin
			in_stall = q_full;
		end
		if ((cmd == tsb_pkg::CMD_HOST) && (q_hit || b_hit)) begin
			in_stall = 1'b1;
		end
	end

	assign accept    = in_valid && !in_stall;
	assign fill_slot = write_slot_q;

	// send window: own half, away from the guard around 0 and 128
	always_comb begin
		c9   = {1'b0, slot_count_q};
		h9   = {2'b00, dead_time_q[7:1]};
		sum9 = c9 + h9;
		win_open = 1'b1;
		if ((sum9 > 9'(tsb_pkg::HALF_POINT)) && (c9 < (9'(tsb_pkg::HALF_POINT) + h9))) begin
			win_open = 1'b0;
		end
		if ((sum9 > 9'd255) || (c9 < h9)) begin
			win_open = 1'b0;
		end
		if (node_odd_q) begin
			if (slot_count_q <= tsb_pkg::HALF_POINT) begin
				win_open = 1'b0;
			end
		end else begin
			if (slot_count_q >= tsb_pkg::HALF_POINT) begin
				win_open = 1'b0;
			end
		end
	end

	assign nxt_write = (write_slot_q == tsb_pkg::SLOT_LAST) ? '0 : write_slot_q + 1'b1;
	assign have_full = (write_slot_q != read_slot_q);
	assign may_flush = (idle_q > flush_to_q) && (fill_q > tsb_pkg::OFF_FIRST) && win_open;

	assign ram_we    = accept && (cmd == tsb_pkg::CMD_HOST);
	assign ram_waddr = tsb_pkg::slot_base(write_slot_q) + tsb_pkg::ADDR_W'(fill_q);
	assign ram_wdata = host_byte;

	always_comb begin
		push      = 1'b0;
		job.ovf   = 1'b0;
		job.slot  = read_slot_q;
		job.len   = tsb_pkg::PKT_LEN;
		job.stamp = slot_count_q;
		if (accept) begin
			if (cmd == tsb_pkg::CMD_HOST) begin
				if ((fill_q == tsb_pkg::OFF_LAST) && (nxt_write == read_slot_q)) begin
					push    = 1'b1;
					job.ovf = 1'b1;
					job.len = 8'd1;
				end
			end else if (cmd == tsb_pkg::CMD_XMIT) begin
				if (have_full) begin
					push = win_open;
				end else if (may_flush) begin
					push     = 1'b1;
					job.slot = write_slot_q;
					job.len  = 8'(fill_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_odd_q  <= 1'b0;
			dead_time_q <= '0;
			xfer_dly_q  <= '0;
			flush_to_q  <= tsb_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsb_pkg::REG_NODE_ODD:  node_odd_q  <= cfg_wdata[0];
				tsb_pkg::REG_DEAD_TIME: dead_time_q <= cfg_wdata[7:0];
				tsb_pkg::REG_XFER_DLY:  xfer_dly_q  <= cfg_wdata[7:0];
				tsb_pkg::REG_FLUSH_TO:  flush_to_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= '0;
			write_slot_q <= '0;
			read_slot_q  <= '0;
			fill_q       <= tsb_pkg::OFF_FIRST;
			idle_q       <= '0;
		end else if (accept) begin
			unique case (cmd)
				tsb_pkg::CMD_HOST: begin
					idle_q <= '0;
					if (fill_q == tsb_pkg::OFF_LAST) begin
						fill_q <= tsb_pkg::OFF_FIRST;
						if (nxt_write != read_slot_q) begin
							write_slot_q <= nxt_write;
						end
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				tsb_pkg::CMD_SLOT: begin
					slot_count_q <= slot_count_q + 1'b1;
				end
				tsb_pkg::CMD_MS: begin
					if (idle_q != tsb_pkg::IDLE_MAX) begin
						idle_q <= idle_q + 1'b1;
					end
				end
				tsb_pkg::CMD_RXHDR: begin
					if (rx_length <= tsb_pkg::PKT_LEN) begin
						slot_count_q <= rx_stamp + xfer_dly_q;
					end
				end
				tsb_pkg::CMD_XMIT: begin
					if (have_full) begin
						if (win_open) begin
							read_slot_q <= (read_slot_q == tsb_pkg::SLOT_LAST) ?
								'0 : read_slot_q + 1'b1;
						end
					end else if (may_flush) begin
						fill_q <= tsb_pkg::OFF_FIRST;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### src/tsb_jobq.sv
// Two-entry job queue between front and back; also reports whether a queued
// packet reads a given slot. Depends on tsb_pkg.
module tsb_jobq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  tsb_pkg::job_t              push_job,
	input  logic                       pop,
	output logic                       q_valid,
	output tsb_pkg::job_t              q_job,
	output logic                       q_full,
	input  logic [tsb_pkg::SLOT_W-1:0] cmp_slot,
	output logic                       q_hit
);

	tsb_pkg::job_t                entry_q [tsb_pkg::JQ_DEPTH];
	logic [tsb_pkg::JQ_DEPTH-1:0] vld_q;
	logic [tsb_pkg::JQ_PW-1:0]    wr_ptr_q;
	logic [tsb_pkg::JQ_PW-1:0]    rd_ptr_q;

	assign q_valid = vld_q[rd_ptr_q];
	assign q_full  = vld_q[wr_ptr_q];
	assign q_job   = entry_q[rd_ptr_q];

	always_comb begin
		q_hit = 1'b0;
		for (int i = 0; i < tsb_pkg::JQ_DEPTH; i++) begin
			if (vld_q[i] && !entry_q[i].ovf && (entry_q[i].slot == cmp_slot)) begin
				q_hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (pop) begin
				vld_q[rd_ptr_q] <= 1'b0;
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push) begin
				vld_q[wr_ptr_q] <= 1'b1;
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into a full queue");

endmodule

### src/tsb_back.sv
// Back end: takes jobs and streams packets (length, stamp, stored payload) or
// overflow beats via a read stage and an output register. Depends on tsb_pkg.
module tsb_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  tsb_pkg::job_t              q_job,
	output logic                       pop,
	input  logic [tsb_pkg::SLOT_W-1:0] cmp_slot,
	output logic                       b_hit,
	output logic                       ram_re,
	output logic [tsb_pkg::ADDR_W-1:0] ram_raddr,
	input  logic [7:0]                 ram_rdata,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       kind,
	output logic [7:0]                 out_byte,
	output logic                       last
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_STREAM = 2'b10
	} bstate_t;

	bstate_t                    state_q;
	tsb_pkg::job_t              cur_q;
	logic [tsb_pkg::ADDR_W-1:0] base_q;
	logic [7:0]                 idx_q;

	logic       s1_valid_s1;
	logic       s1_kind_s1;
	logic       s1_ram_s1;
	logic [7:0] s1_imm_s1;
	logic       s1_last_s1;

	logic       out_valid_s2;
	logic       kind_s2;
	logic [7:0] byte_s2;
	logic       last_s2;

	logic active;
	logic adv;
	logic issue;
	logic idx_last;

	assign active   = (state_q == ST_STREAM);
	assign adv      = !out_valid_s2 || !out_stall;
	assign issue    = active && adv;
	assign idx_last = (idx_q == (cur_q.len - 1'b1));
	assign pop      = !active && q_valid;

	assign b_hit     = active && !cur_q.ovf && (cur_q.slot == cmp_slot);
	assign ram_re    = issue && !cur_q.ovf && (idx_q > 8'd1);
	assign ram_raddr = base_q + tsb_pkg::ADDR_W'(idx_q);

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q  <= q_job;
			base_q <= tsb_pkg::slot_base(q_job.slot);
		end
		if (issue) begin
			s1_kind_s1 <= cur_q.ovf;
			s1_ram_s1  <= !cur_q.ovf && (idx_q > 8'd1);
			s1_last_s1 <= idx_last;
			if (cur_q.ovf) begin
				s1_imm_s1 <= 8'd0;
			end else if (idx_q == 8'd0) begin
				s1_imm_s1 <= cur_q.len;
			end else begin
				s1_imm_s1 <= cur_q.stamp;
			end
		end
		if (adv) begin
			kind_s2 <= s1_kind_s1;
			byte_s2 <= s1_ram_s1 ? ram_rdata : s1_imm_s1;
			last_s2 <= s1_last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			s1_valid_s1  <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_STREAM;
						idx_q   <= '0;
					end
				end
				ST_STREAM: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
						if (idx_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (adv) begin
				s1_valid_s1  <= issue;
				out_valid_s2 <= s1_valid_s1;
			end
		end
	end

	assign out_valid = out_valid_s2;
	assign kind      = kind_s2;
	assign out_byte  = byte_s2;
	assign last      = last_s2;

	a_ovf_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && kind_s2 |-> last_s2 && (byte_s2 == 8'd0))
		else $error("overflow beat without last or with data");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		active |-> (idx_q < cur_q.len))
		else $error("byte index ran past packet length");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !adv |=> s1_valid_s1 && $stable(s1_imm_s1) && $stable(s1_ram_s1))
		else $error("read stage changed while output was stalled");

endmodule

### src/tdma_slot_packet_bridge.sv
// Top level of the slot packet bridge: front end, job queue, back end, packet store.
// Depends on tsb_pkg, tsb_front, tsb_jobq, tsb_back and tsb_ram.
//
// Usage:
//  - Input channel (in_valid/in_stall, cmd + host_byte/rx_length/rx_stamp): one beat per
//    command. A host byte stalls while the slot it fills is still being
//    read out (a flushed partial packet, or a full packet after the ring wraps).
//    Host bytes and transmit opportunities also stall while the job queue (two
//    entries) is full.
//  - Output channel (out_valid/out_stall, kind/out_byte/last): packet bytes and
//    overflow beats. A transmit opportunity's job is registered in the queue, then
//    loaded by the back end once it is idle, then passes the read stage and the
//    output register. Bytes follow at one per cycle while the output is not stalled,
//    and the output idles between jobs while the back end loads the next job.
//  - A stalled output holds its beat; the read stage holds too, so nothing is lost.
//    The front end keeps taking beats; a full queue stalls host bytes and transmits.
//  - Config port: cfg_we/cfg_index/cfg_wdata, write only while idle.
//  - Reset clears pointers, counters, queue and config (flush timeout to 100).
//    The packet store is not cleared; only written bytes are ever sent.
module tdma_slot_packet_bridge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [2:0]                cmd,
	input  logic [7:0]                host_byte,
	input  logic [7:0]                rx_length,
	input  logic [7:0]                rx_stamp,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      kind,
	output logic [7:0]                out_byte,
	output logic                      last,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [tsb_pkg::CFG_W-1:0] cfg_wdata
);

	// front -> queue
	logic          push;
	tsb_pkg::job_t push_job;
	logic          q_full;
	logic          q_hit;

	// queue -> back
	logic          q_valid;
	tsb_pkg::job_t q_job;
	logic          pop;
	logic          b_hit;

	// slot the host is filling, checked against pending reads
	logic [tsb_pkg::SLOT_W-1:0] fill_slot;

	// store ports
	logic                       ram_we;
	logic [tsb_pkg::ADDR_W-1:0] ram_waddr;
	logic [7:0]                 ram_wdata;
	logic                       ram_re;
	logic [tsb_pkg::ADDR_W-1:0] ram_raddr;
	logic [7:0]                 ram_rdata;

	tsb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.host_byte (host_byte),
		.rx_length (rx_length),
		.rx_stamp  (rx_stamp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_hit     (q_hit),
		.b_hit     (b_hit),
		.fill_slot (fill_slot),
		.push      (push),
		.job       (push_job),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	tsb_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.q_full   (q_full),
		.cmp_slot (fill_slot),
		.q_hit    (q_hit)
	);

	tsb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.pop       (pop),
		.cmp_slot  (fill_slot),
		.b_hit     (b_hit),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.out_byte  (out_byte),
		.last      (last)
	);

	// packet store: one byte per ring slot offset
	tsb_ram #(
		.WIDTH (8),
		.DEPTH (tsb_pkg::STORE_SIZE)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for tdma_slot_packet_bridge: directed table, one full packet, random traffic.
// Depends on tsb_pkg and the bridge RTL; expected beats come from a behavioral mirror below.
module tb_top;

	localparam int CLK_PERIOD   = 12;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int HOLD_CYCLES  = 8;      // covers store read + job queue after the last beat
	localparam int DRAIN_MAX    = 50_000;
	localparam int RAND_ITEMS   = 20;     // per idling phase

	// Command codes the block ignores
	localparam logic [2:0] CMD_SPARE5 = 3'd5;
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	localparam logic KIND_PKT = 1'b0;
	localparam logic KIND_OVF = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
	} beat_t;

	typedef enum logic [0:0] {ROW_BEAT, ROW_CFG} row_op_t;

	// One directed step: an input beat, or a full register update (all four written)
	typedef struct packed {
		row_op_t    op;
		logic [2:0] cmd;
		logic [7:0] hb;
		logic [7:0] rlen;
		logic [7:0] rstamp;
		logic       quiet;    // 1: nothing may come out for this beat
		logic       node;
		logic [7:0] dead;
		logic [7:0] delay;
		logic [15:0] tmo;
	} row_t;

	localparam int PLAN_ROWS = 27;

	// Defaults after reset: even node, no guard, no delay, timeout 100 ms.
	row_t plan [PLAN_ROWS] = '{
		// empty ring
		'{ROW_BEAT, tsb_pkg::CMD_XMIT,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, CMD_SPARE5,         8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, CMD_SPARE6,         8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, CMD_SPARE7,         8'h55, 8'hAA, 8'h5A, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, tsb_pkg::CMD_HOST,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, tsb_pkg::CMD_HOST,  8'hFF, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, tsb_pkg::CMD_HOST,  8'hA5, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, tsb_pkg::CMD_MS,    8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		// 1 ms < 100
		'{ROW_BEAT, tsb_pkg::CMD_XMIT,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_CFG,  tsb_pkg::CMD_HOST,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0},
		// flush 5
		'{ROW_BEAT, tsb_pkg::CMD_XMIT,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0},
		// nothing left
		'{ROW_BEAT, tsb_pkg::CMD_XMIT,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		// len == max, then too long
		'{ROW_BEAT, tsb_pkg::CMD_RXHDR, 8'h00, 8'h40, 8'h80, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, tsb_pkg::CMD_RXHDR, 8'h00, 8'h41, 8'h05, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, tsb_pkg::CMD_HOST,  8'h5A, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, tsb_pkg::CMD_MS,    8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		// slot 128
		'{ROW_BEAT, tsb_pkg::CMD_XMIT,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, tsb_pkg::CMD_SLOT,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_CFG,  tsb_pkg::CMD_HOST,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'hFF, 8'hFF, 16'd0},
		// full guard
		'{ROW_BEAT, tsb_pkg::CMD_XMIT,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		// -> 255
		'{ROW_BEAT, tsb_pkg::CMD_RXHDR, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_CFG,  tsb_pkg::CMD_HOST,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'hFF, 16'd0},
		// flush 3
		'{ROW_BEAT, tsb_pkg::CMD_XMIT,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0},
		// wrap to 0
		'{ROW_BEAT, tsb_pkg::CMD_SLOT,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, tsb_pkg::CMD_HOST,  8'h11, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		'{ROW_BEAT, tsb_pkg::CMD_MS,    8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0},
		// odd, slot 0
		'{ROW_BEAT, tsb_pkg::CMD_XMIT,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 16'd0}
	};

	// DUT ports
	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic [2:0]                cmd       = tsb_pkg::CMD_HOST;
	logic [7:0]                host_byte = 8'h00;
	logic [7:0]                rx_length = 8'h00;
	logic [7:0]                rx_stamp  = 8'h00;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      kind;
	logic [7:0]                out_byte;
	logic                      last;
	logic                      cfg_we    = 1'b0;
	logic [1:0]                cfg_index = tsb_pkg::REG_NODE_ODD;
	logic [tsb_pkg::CFG_W-1:0] cfg_wdata = '0;

	// Mirror of the bridge: register settings and state
	logic                       set_node_odd = 1'b0;
	logic [7:0]                 set_dead     = 8'd0;
	logic [7:0]                 set_delay    = 8'd0;
	logic [15:0]                set_flush_to = tsb_pkg::TIMEOUT_RST;
	logic [7:0]                 slot_ctr     = 8'd0;
	logic [7:0]                 pkt_mem [tsb_pkg::STORE_SIZE];
	logic [tsb_pkg::SLOT_W-1:0] wr_slot      = '0;
	logic [tsb_pkg::SLOT_W-1:0] rd_slot      = '0;
	logic [tsb_pkg::OFF_W-1:0]  fill_off     = tsb_pkg::OFF_FIRST;
	logic [15:0]                idle_ms_ctr  = 16'd0;

	beat_t step_beats [$];   // beats caused by the beat just accepted
	beat_t radio_q [$];      // beats still owed on the output, oldest first

	int idle_pct  = 0;
	int stall_pct = 0;
	int errors    = 0;
	int n_items   = 0;
	int n_checked = 0;
	int n_full    = 0;
	int n_flush   = 0;
	int n_ovf     = 0;
	int n_cfg     = 0;

	tdma_slot_packet_bridge dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.host_byte (host_byte),
		.rx_length (rx_length),
		.rx_stamp  (rx_stamp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.out_byte  (out_byte),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------- mirror

	// Send window: own half of the slot counter, minus the guard around 0 and 128.
	function automatic bit slot_window_open();
		int unsigned h, c;
		h = set_dead / 2;
		c = slot_ctr;
		if (c + h > tsb_pkg::HALF_POINT && c < tsb_pkg::HALF_POINT + h)
			return 1'b0;
		if (c + h > 255 || c < h)
			return 1'b0;
		return set_node_odd ? (c > tsb_pkg::HALF_POINT) : (c < tsb_pkg::HALF_POINT);
	endfunction

	// Length byte, stamp (slot counter now), then stored payload from offset 2.
	function automatic void stream_packet(input logic [tsb_pkg::SLOT_W-1:0] s, input int len);
		int base, i;
		logic [7:0] b;
		base = int'(s) * tsb_pkg::PACKET_BYTES;
		for (i = 0; i < len; i++) begin
			if (i == 0)
				b = 8'(len);
			else if (i == 1)
				b = slot_ctr;
			else
				b = pkt_mem[base + i];
			step_beats.push_back('{KIND_PKT, b, (i == len - 1)});
		end
	endfunction

	function automatic void predict_beats(input logic [2:0] c, input logic [7:0] hb, rl, rs);
		logic [tsb_pkg::SLOT_W-1:0] nxt;
		nxt = wr_slot + 1'b1;
		unique case (c)
			tsb_pkg::CMD_HOST: begin
				pkt_mem[int'(wr_slot) * tsb_pkg::PACKET_BYTES + int'(fill_off)] = hb;
				idle_ms_ctr = 16'd0;
				if (fill_off != tsb_pkg::OFF_LAST) begin
					fill_off = fill_off + 1'b1;
				end else begin
					fill_off = tsb_pkg::OFF_FIRST;
					// ring full: the packet just filled is dropped, queued ones stay intact
					if (nxt == rd_slot) begin
						step_beats.push_back('{KIND_OVF, 8'h00, 1'b1});
						n_ovf++;
					end else begin
						wr_slot = nxt;
					end
				end
			end
			tsb_pkg::CMD_SLOT: slot_ctr = slot_ctr + 1'b1;
			tsb_pkg::CMD_MS: begin
				if (idle_ms_ctr != tsb_pkg::IDLE_MAX)
					idle_ms_ctr = idle_ms_ctr + 1'b1;
			end
			tsb_pkg::CMD_RXHDR: begin
				if (rl <= tsb_pkg::PKT_LEN)
					slot_ctr = rs + set_delay;
			end
			tsb_pkg::CMD_XMIT: begin
				// a queued full packet takes priority and blocks the flush even when held back
				if (wr_slot != rd_slot) begin
					if (slot_window_open()) begin
						stream_packet(rd_slot, tsb_pkg::PACKET_BYTES);
						rd_slot = rd_slot + 1'b1;
						n_full++;
					end
				end else if (idle_ms_ctr > set_flush_to && fill_off > tsb_pkg::OFF_FIRST &&
						slot_window_open()) begin
					stream_packet(wr_slot, int'(fill_off));
					fill_off = tsb_pkg::OFF_FIRST;   // idle time is kept
					n_flush++;
				end
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers

	// One input beat; idle gaps before it, expectations queued once it is taken.
	task automatic drive_beat(input logic [2:0] c, input logic [7:0] hb, rl, rs,
			input logic quiet);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		host_byte <= hb;
		rx_length <= rl;
		rx_stamp  <= rs;
		do @(posedge clk); while (in_stall);
		step_beats.delete();
		predict_beats(c, hb, rl, rs);
		// quiet rows carry their own answer: no beat at all
		if (!quiet)
			foreach (step_beats[i]) radio_q.push_back(step_beats[i]);
		n_items++;
	endtask

	// A beat of the given command with random payload fields, checked by the mirror.
	task automatic drive_rand(input logic [2:0] c);
		drive_beat(c, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
	endtask

	// Hold the input until every owed beat is out, then let the pipeline empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (radio_q.size() != 0) @(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_apply(input logic node, input logic [7:0] dead, delay,
			input logic [15:0] tmo);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= tsb_pkg::REG_NODE_ODD;
		cfg_wdata <= tsb_pkg::CFG_W'(node);
		@(posedge clk);
		cfg_index <= tsb_pkg::REG_DEAD_TIME;
		cfg_wdata <= tsb_pkg::CFG_W'(dead);
		@(posedge clk);
		cfg_index <= tsb_pkg::REG_XFER_DLY;
		cfg_wdata <= tsb_pkg::CFG_W'(delay);
		@(posedge clk);
		cfg_index <= tsb_pkg::REG_FLUSH_TO;
		cfg_wdata <= tsb_pkg::CFG_W'(tmo);
		@(posedge clk);
		cfg_we <= 1'b0;
		set_node_odd = node;
		set_dead     = dead;
		set_delay    = delay;
		set_flush_to = tmo;
		n_cfg++;
	endtask

	// Random traffic built from short sequences: host bursts, tick runs, headers that
	// move the slot counter, flush attempts, and noise. Every beat counts toward target.
	task automatic random_traffic(input int target);
		int done, len, pick;
		logic [7:0] rl;
		done = 0;
		while (done < target) begin
			pick = $urandom_range(0, 12);
			unique case (pick)
				0, 1, 2, 3: begin
					len = ($urandom_range(0, 4) == 0) ? tsb_pkg::PACKET_BYTES - 2
						: $urandom_range(1, 20);
					if (len > target - done)
						len = target - done;
					repeat (len) drive_rand(tsb_pkg::CMD_HOST);
					done += len;
				end
				4: begin
					len = $urandom_range(1, 3);
					if (len > target - done)
						len = target - done;
					repeat (len) drive_rand(tsb_pkg::CMD_MS);
					done += len;
				end
				5: begin
					len = $urandom_range(1, 6);
					if (len > target - done)
						len = target - done;
					repeat (len) drive_rand(tsb_pkg::CMD_SLOT);
					done += len;
				end
				6: begin
					rl = ($urandom_range(0, 3) == 0) ?
						8'($urandom_range(tsb_pkg::PACKET_BYTES + 1, 255))
						: 8'($urandom_range(0, tsb_pkg::PACKET_BYTES));
					drive_beat(tsb_pkg::CMD_RXHDR, 8'($urandom), rl, 8'($urandom), 1'b0);
					done++;
				end
				7, 8: begin
					drive_rand(tsb_pkg::CMD_XMIT);
					done++;
				end
				9, 10: begin
					// idle just past a short timeout, then ask to send
					if (set_flush_to < 16'd5) begin
						len = int'(set_flush_to) + 1;
						repeat (len) drive_rand(tsb_pkg::CMD_MS);
						done += len;
					end
					drive_rand(tsb_pkg::CMD_XMIT);
					done++;
				end
				11: begin
					drive_rand(3'($urandom_range(CMD_SPARE5, CMD_SPARE7)));
					done++;
				end
				default: settle();
			endcase
		end
	endtask

	// ---------------------------------------------------------------- output check

	// Inputs are sampled before this edge's updates land, so checks see settled values.
	always @(posedge clk) begin
		beat_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{kind, out_byte, last};
			if (radio_q.size() == 0) begin
				errors++;
				$display("%0t: expected no beat, got kind=%0d byte=%02h last=%0d",
					$time, got.kind, got.data, got.last);
			end else begin
				want = radio_q.pop_front();
				if (got.kind !== want.kind || got.data !== want.data ||
						got.last !== want.last) begin
					errors++;
					$display("%0t: expected k=%0d b=%02h l=%0d, got k=%0d b=%02h l=%0d",
						$time, want.kind, want.data, want.last,
						got.kind, got.data, got.last);
				end
			end
			n_checked++;
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// ---------------------------------------------------------------- stimulus

	initial begin
		int w;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase 1: no idling on either side.
		foreach (plan[r]) begin
			if (plan[r].op == ROW_CFG)
				cfg_apply(plan[r].node, plan[r].dead, plan[r].delay, plan[r].tmo);
			else
				drive_beat(plan[r].cmd, plan[r].hb, plan[r].rlen, plan[r].rstamp,
					plan[r].quiet);
		end

		// Idle timeout edge: idle equal to the timeout holds a partial packet back,
		// one more millisecond lets it go.
		cfg_apply(1'b0, 8'd0, 8'd0, 16'd3);
		drive_beat(tsb_pkg::CMD_RXHDR, 8'h00, 8'd8, 8'd16, 1'b0);
		repeat (3) drive_rand(tsb_pkg::CMD_HOST);
		repeat (3) drive_rand(tsb_pkg::CMD_MS);
		drive_rand(tsb_pkg::CMD_XMIT);
		drive_rand(tsb_pkg::CMD_MS);
		drive_rand(tsb_pkg::CMD_XMIT);

		cfg_apply(1'b0, 8'd20, 8'd7, 16'd2);
		random_traffic(RAND_ITEMS);

		// Phase 2: sender idle most of the time.
		idle_pct = 68;
		cfg_apply(1'b1, 8'd0, 8'd255, 16'd0);
		random_traffic(RAND_ITEMS);

		// Phase 3: receiver stalls most of the time. Complete one whole payload, then
		// drain every queued packet with the window held open.
		idle_pct  = 0;
		stall_pct = 68;
		cfg_apply(1'b0, 8'd0, 8'd0, tsb_pkg::IDLE_MAX);
		drive_beat(tsb_pkg::CMD_RXHDR, 8'($urandom),
			8'($urandom_range(0, tsb_pkg::PACKET_BYTES)), 8'd0, 1'b0);
		while (wr_slot == rd_slot)
			drive_rand(tsb_pkg::CMD_HOST);
		while (wr_slot != rd_slot)
			drive_rand(tsb_pkg::CMD_XMIT);
		drive_rand(tsb_pkg::CMD_XMIT);
		cfg_apply(1'b1, 8'd100, 8'd128, 16'd3);
		random_traffic(RAND_ITEMS);

		// Phase 4: light idling on both sides.
		idle_pct  = 8;
		stall_pct = 8;
		cfg_apply(1'b0, 8'd9, 8'd1, 16'd1);
		random_traffic(RAND_ITEMS);

		in_valid <= 1'b0;
		for (w = 0; w < DRAIN_MAX && radio_q.size() != 0; w++)
			@(posedge clk);
		if (radio_q.size() != 0) begin
			errors++;
			$display("%0t: expected %0d more beats, next byte=%02h, got none",
				$time, radio_q.size(), radio_q[0].data);
		end
		repeat (2 * HOLD_CYCLES) @(posedge clk);

		$display("Covered %0d input beats over %0d register settings:", n_items, n_cfg);
		$display("  %0d full packets, %0d flushes, %0d overflows, %0d output beats checked.",
			n_full, n_flush, n_ovf, n_checked);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
src/tsb_pkg.sv
src/tsb_ram.sv
src/tsb_front.sv
src/tsb_jobq.sv
src/tsb_back.sv
src/tdma_slot_packet_bridge.sv
verif/tb_top.sv
